@@ hw/rtl/mstb_pkg.sv @@
// Shared types and constants for the interval timer bank.
`timescale 1ns / 1ps

package mstb_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int ACT_W     = 2;
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK           = 2'd0,
    ACT_START_PERIODIC = 2'd1,
    ACT_START_ONCE     = 2'd2,
    ACT_STOP           = 2'd3
  } action_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } scan_state_t;

  // write request into the slot store
  typedef struct packed {
    logic              wr_period;
    logic              wr_base;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] base;
    logic              one_shot;
  } slot_wr_t;

  // slot contents as read back (reset values for never-written entries)
  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] base;
    logic              one_shot;
  } slot_rd_t;

endpackage

@@ hw/rtl/mstb_if.sv @@
// Command and fire-event channel interfaces.
`timescale 1ns / 1ps

interface mstb_cmd_if
  import mstb_pkg::*;
();
  logic              valid;
  logic              ready;
  action_t           action;
  logic [SLOT_W-1:0] slot;
  logic [TIME_W-1:0] period_ms;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, action, slot, period_ms, now_ms, input ready);
  modport sink   (input valid, action, slot, period_ms, now_ms, output ready);
endinterface

interface mstb_evt_if
  import mstb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] fired_slot;
  logic              last_fired;

  modport source (output valid, fired_slot, last_fired, input ready);
  modport sink   (input valid, fired_slot, last_fired, output ready);
endinterface

@@ hw/rtl/mstb_slot_mem.sv @@
// Slot store: period memory and base/mode memory, registered synchronous read.
`timescale 1ns / 1ps

module mstb_slot_mem
  import mstb_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output slot_rd_t      rd_data,
  input  logic [AW-1:0] wr_addr,
  input  slot_wr_t      wr
);

  logic [TIME_W-1:0] period_mem [SLOTS];
  logic [TIME_W:0]   base_mem   [SLOTS];   // {one_shot, base}

  // entries never written read as their reset value
  logic [SLOTS-1:0]  period_vld;
  logic [SLOTS-1:0]  base_vld;

  logic [TIME_W-1:0] period_q;
  logic [TIME_W:0]   base_q;
  logic              period_vld_q;
  logic              base_vld_q;

  always_ff @(posedge clk) begin
    if (wr.wr_period) begin
      period_mem[wr_addr] <= wr.period;
    end
    if (wr.wr_base) begin
      base_mem[wr_addr] <= {wr.one_shot, wr.base};
    end
    if (rd_en) begin
      period_q <= period_mem[rd_addr];
      base_q   <= base_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_vld   <= '0;
      base_vld     <= '0;
      period_vld_q <= 1'b0;
      base_vld_q   <= 1'b0;
    end else begin
      if (wr.wr_period) begin
        period_vld[wr_addr] <= 1'b1;
      end
      if (wr.wr_base) begin
        base_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        period_vld_q <= period_vld[rd_addr];
        base_vld_q   <= base_vld[rd_addr];
      end
    end
  end

  assign rd_data.period   = period_vld_q ? period_q : '0;
  assign rd_data.base     = base_vld_q ? base_q[TIME_W-1:0] : '0;
  assign rd_data.one_shot = base_vld_q ? base_q[TIME_W] : 1'b1;

endmodule

@@ hw/rtl/multi_slot_interval_timer_bank_top.sv @@
// Top level of the periodic and one-shot interval timer bank.
`timescale 1ns / 1ps

// Start and stop transactions are written to the slot store in their accept cycle;
// the block stays in idle with ready high for the next transaction.
// A tick scans the slot store, one read per cycle: after its accept it stays busy
// for SLOTS reads, an evaluate tail and a drain before the next tick is taken;
// output backpressure with two fires pending stalls the scan.
// Reset stops all slots by clearing per-entry valid bits; there is no clearing pass.

module multi_slot_interval_timer_bank_top
  import mstb_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  mstb_cmd_if.sink   cmd,
  mstb_evt_if.source evt
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  scan_state_t       state, state_next;

  // read pointer of the scan; SLOTS means all reads issued
  logic [CW-1:0]     ra, ra_next;

  // evaluate stage: memory data for slot e_idx is on rd_data
  logic              e_vld, e_vld_next;
  logic [AW-1:0]     e_idx, e_idx_next;
  logic [TIME_W-1:0] now_q;

  // one fire held back until we know whether it is the last of the tick
  logic              pend_vld, pend_vld_next;
  logic [AW-1:0]     pend_idx, pend_idx_next;

  // output register
  logic              out_vld, out_vld_next;
  logic [SLOT_W-1:0] out_slot, out_slot_next;
  logic              out_last, out_last_next;

  logic              cmd_ready;
  logic              slot_ok;
  logic              ra_lt;
  logic              out_free;
  logic              fire;
  logic              go;
  logic              issue;
  logic [TIME_W-1:0] elapsed;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  slot_rd_t          rd_data;
  logic [AW-1:0]     wr_addr;
  slot_wr_t          wr;

  mstb_slot_mem #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr      (wr)
  );

  assign slot_ok  = 32'(cmd.slot) < SLOTS;
  assign ra_lt    = ra < CW'(SLOTS);
  assign out_free = !out_vld || evt.ready;
  assign elapsed  = now_q - rd_data.base;
  assign fire     = e_vld && (rd_data.period != '0) && (elapsed >= rd_data.period);
  // stall only when a new fire needs the pending slot moved out and the output is full
  assign go       = !(fire && pend_vld && !out_free);
  assign issue    = (state == S_SCAN) && go && ra_lt;

  always_comb begin
    state_next    = state;
    ra_next       = ra;
    e_vld_next    = e_vld;
    e_idx_next    = e_idx;
    pend_vld_next = pend_vld;
    pend_idx_next = pend_idx;
    out_vld_next  = out_vld;
    out_slot_next = out_slot;
    out_last_next = out_last;
    cmd_ready     = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = ra[AW-1:0];
    wr_addr       = e_idx;
    wr            = '0;

    if (out_vld && evt.ready) begin
      out_vld_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd.valid) begin
          unique case (cmd.action)
            ACT_TICK: begin
              state_next = S_SCAN;
              ra_next    = '0;
            end
            ACT_STOP: begin
              wr_addr      = AW'(cmd.slot);
              wr.wr_period = slot_ok;
            end
            ACT_START_PERIODIC, ACT_START_ONCE: begin
              wr_addr      = AW'(cmd.slot);
              wr.wr_period = slot_ok;
              wr.wr_base   = slot_ok;
              wr.period    = cmd.period_ms;
              wr.base      = cmd.now_ms;
              wr.one_shot  = (cmd.action == ACT_START_ONCE);
            end
          endcase
        end
      end

      S_SCAN: begin
        if (go) begin
          if (fire) begin
            wr_addr      = e_idx;
            wr.wr_period = 1'b1;
            wr.wr_base   = 1'b1;
            wr.period    = rd_data.one_shot ? '0 : rd_data.period;
            wr.base      = rd_data.base + rd_data.period;
            wr.one_shot  = rd_data.one_shot;
            if (pend_vld) begin
              out_vld_next  = 1'b1;
              out_slot_next = SLOT_W'(pend_idx);
              out_last_next = 1'b0;
            end
            pend_vld_next = 1'b1;
            pend_idx_next = e_idx;
          end
          if (ra_lt) begin
            rd_en      = 1'b1;
            ra_next    = ra + CW'(1);
            e_vld_next = 1'b1;
            e_idx_next = ra[AW-1:0];
          end else begin
            e_vld_next = 1'b0;
          end
        end
        // scan finished: release the held fire as the last one
        if (!e_vld && !ra_lt) begin
          if (!pend_vld) begin
            state_next = S_IDLE;
          end else if (out_free) begin
            out_vld_next  = 1'b1;
            out_slot_next = SLOT_W'(pend_idx);
            out_last_next = 1'b1;
            pend_vld_next = 1'b0;
            state_next    = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ra       <= '0;
      e_vld    <= 1'b0;
      pend_vld <= 1'b0;
      out_vld  <= 1'b0;
    end else begin
      state    <= state_next;
      ra       <= ra_next;
      e_vld    <= e_vld_next;
      pend_vld <= pend_vld_next;
      out_vld  <= out_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    e_idx    <= e_idx_next;
    pend_idx <= pend_idx_next;
    out_slot <= out_slot_next;
    out_last <= out_last_next;
    if (cmd.valid && cmd_ready && (cmd.action == ACT_TICK)) begin
      now_q <= cmd.now_ms;
    end
  end

  assign cmd.ready      = cmd_ready;
  assign evt.valid      = out_vld;
  assign evt.fired_slot = out_slot;
  assign evt.last_fired = out_last;

  // idle means the scan pipeline and the held fire are empty
  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!e_vld && !pend_vld))
    else $error("scan state left behind in idle");

  // a read issued now is evaluated next cycle for the same slot
  a_issue_eval : assert property (@(posedge clk) disable iff (rst)
    issue |=> (e_vld && (e_idx == $past(ra[AW-1:0]))))
    else $error("evaluate stage lost track of issued read");

  // during a scan the store is written only for a fired slot
  a_scan_write : assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && (wr.wr_period || wr.wr_base)) |-> (fire && go))
    else $error("slot store written without a fire");

  // read pointer never runs past the bank
  a_ra_range : assert property (@(posedge clk) disable iff (rst)
    ra <= CW'(SLOTS))
    else $error("scan pointer out of range");

endmodule

@@ tb/tb_multi_slot_interval_timer_bank_top.sv @@
// Self-checking testbench for the interval timer bank: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_multi_slot_interval_timer_bank_top;
  import mstb_pkg::*;

  localparam int NSLOT      = SLOTS_DEF;
  localparam int RAND_ITEMS = 450;
  localparam int IDLE_LIMIT = 5000;  // cycles with no transaction on either side
  localparam int DRAIN_WAIT = NSLOT + 3 + 20;
  localparam int NPLAN      = 25;

  // one command transaction
  typedef struct {
    action_t           act;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now;
  } timer_cmd_t;

  // one fire event
  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              last;
  } fire_evt_t;

  // directed row: typed=1 means fires holds the expected fire set for a tick
  typedef struct {
    action_t           act;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now;
    bit                typed;
    logic [NSLOT-1:0]  fires;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mstb_cmd_if cmd_ch ();
  mstb_evt_if evt_ch ();

  multi_slot_interval_timer_bank_top #(
    .SLOTS(NSLOT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .evt(evt_ch)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Directed table. Slot 0 period 1 walks the wrap at 2^32; slot 15 uses the
  // largest period in one-shot mode; slot 5 is armed with a zero period and
  // must stay silent; slot 3 is a one-shot armed just below the wrap.
  plan_row_t plan [NPLAN] = '{
    '{ACT_TICK,           4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 16'h0000},
    '{ACT_TICK,           4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'h0000},
    '{ACT_START_PERIODIC, 4'd0,  32'h0000_0001, 32'h0000_0000, 1'b0, 16'h0000},
    '{ACT_START_ONCE,     4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 16'h0000},
    '{ACT_START_PERIODIC, 4'd5,  32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0000},
    '{ACT_TICK,           4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 16'h0000},
    '{ACT_TICK,           4'd0,  32'h0000_0000, 32'h0000_0001, 1'b1, 16'h0001},
    '{ACT_TICK,           4'd0,  32'h0000_0000, 32'h0000_0001, 1'b1, 16'h0000},
    '{ACT_TICK,           4'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 16'h8001},
    '{ACT_TICK,           4'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 16'h0001},
    '{ACT_START_ONCE,     4'd3,  32'h0000_000A, 32'hFFFF_FFFA, 1'b0, 16'h0000},
    '{ACT_TICK,           4'd0,  32'h0000_0000, 32'h0000_0004, 1'b0, 16'h0000},
    '{ACT_STOP,           4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0000},
    '{ACT_STOP,           4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0000},
    '{ACT_TICK,           4'd0,  32'h0000_0000, 32'h0000_0064, 1'b1, 16'h0000},
    '{ACT_START_PERIODIC, 4'd1,  32'h0000_0002, 32'h0000_0064, 1'b0, 16'h0000},
    '{ACT_START_ONCE,     4'd2,  32'h0000_0002, 32'h0000_0064, 1'b0, 16'h0000},
    '{ACT_START_PERIODIC, 4'd14, 32'h0000_0003, 32'h0000_0064, 1'b0, 16'h0000},
    '{ACT_START_PERIODIC, 4'd10, 32'h8000_0000, 32'h0000_0064, 1'b0, 16'h0000},
    '{ACT_TICK,           4'd0,  32'h0000_0000, 32'h0000_0066, 1'b0, 16'h0000},
    '{ACT_TICK,           4'd0,  32'h0000_0000, 32'h0000_0067, 1'b0, 16'h0000},
    '{ACT_TICK,           4'd0,  32'h0000_0000, 32'h0000_0068, 1'b0, 16'h0000},
    '{ACT_TICK,           4'd0,  32'h0000_0000, 32'h8000_0064, 1'b0, 16'h0000},
    '{ACT_STOP,           4'd10, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0000},
    '{ACT_STOP,           4'd14, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0000}
  };

  // timer state as the testbench sees it
  logic [TIME_W-1:0] tmr_period [NSLOT];
  logic [TIME_W-1:0] tmr_base   [NSLOT];
  logic              tmr_once   [NSLOT];

  fire_evt_t fire_q [$];  // fire events still owed by the block

  int err_cnt     = 0;
  int n_tick      = 0;
  int n_start     = 0;
  int n_stop      = 0;
  int n_fire      = 0;
  int max_fires   = 0;
  int idle_cycles = 0;

  logic [TIME_W-1:0] cur_now = '0;  // running time base for the random part
  logic              calm    = 1'b0; // no idling on either side while set
  int unsigned       calm_left = 0;
  int unsigned       sink_hold = 0;
  fire_evt_t         exp_evt;

  // Apply one command to the timer state; returns the set of slots that fire.
  function automatic logic [NSLOT-1:0] advance_timers(timer_cmd_t c);
    logic [NSLOT-1:0]  fired;
    logic [TIME_W-1:0] elapsed;
    fired = '0;
    case (c.act)
      ACT_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (tmr_period[i] != '0) begin
            elapsed = c.now - tmr_base[i];
            if (elapsed >= tmr_period[i]) begin
              tmr_base[i] = tmr_base[i] + tmr_period[i];
              if (tmr_once[i]) tmr_period[i] = '0;
              fired[i] = 1'b1;
            end
          end
        end
      end
      ACT_STOP: begin
        tmr_period[c.slot] = '0;
      end
      default: begin
        tmr_once[c.slot]   = (c.act == ACT_START_ONCE);
        tmr_period[c.slot] = c.period;
        tmr_base[c.slot]   = c.now;
      end
    endcase
    return fired;
  endfunction

  // Queue one fire event per set bit, ascending; the highest one is marked last.
  function automatic void owe_fires(logic [NSLOT-1:0] fired);
    int top;
    int cnt;
    top = -1;
    cnt = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (fired[i]) begin
        top = i;
        cnt++;
      end
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (fired[i]) fire_q.push_back('{slot: 4'(i), last: (i == top)});
    end
    n_fire += cnt;
    if (cnt > max_fires) max_fires = cnt;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Drive one command, wait for its transaction, then predict and maybe idle.
  task automatic issue(timer_cmd_t c, bit typed, logic [NSLOT-1:0] typed_fires);
    logic [NSLOT-1:0] fired;
    int unsigned      gap;
    cmd_ch.valid     <= 1'b1;
    cmd_ch.action    <= c.act;
    cmd_ch.slot      <= c.slot;
    cmd_ch.period_ms <= c.period;
    cmd_ch.now_ms    <= c.now;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    fired = advance_timers(c);
    owe_fires(typed ? typed_fires : fired);
    case (c.act)
      ACT_TICK: n_tick++;
      ACT_STOP: n_stop++;
      default:  n_start++;
    endcase
    gap = pick_gap();
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random period: mostly short, some zero, some full range, some near the top.
  function automatic logic [TIME_W-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 20);
    if (r < 80) return '0;
    if (r < 90) return $urandom();
    return 32'hFFFF_FFFF - $urandom_range(0, 15);
  endfunction

  // Calm stretches come and go, flipped with NBA so all readers see one value.
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(50, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // Event sink: check each accepted fire event, then decide next ready.
  always @(posedge clk) begin
    int unsigned hold_len;
    if (rst) begin
      evt_ch.ready <= 1'b1;
    end else begin
      if (evt_ch.valid && evt_ch.ready) begin
        if (fire_q.size() == 0) begin
          $error("fired_slot: no transaction expected, got %0d (last_fired %0b)",
                 evt_ch.fired_slot, evt_ch.last_fired);
          err_cnt++;
        end else begin
          exp_evt = fire_q.pop_front();
          if (evt_ch.fired_slot !== exp_evt.slot) begin
            $error("fired_slot: expected %0d, got %0d", exp_evt.slot, evt_ch.fired_slot);
            err_cnt++;
          end
          if (evt_ch.last_fired !== exp_evt.last) begin
            $error("last_fired: expected %0b, got %0b", exp_evt.last, evt_ch.last_fired);
            err_cnt++;
          end
        end
      end
      if (sink_hold != 0) begin
        sink_hold    <= sink_hold - 1;
        evt_ch.ready <= (sink_hold == 1);
      end else if ($urandom_range(0, 5) == 0) begin
        hold_len      = pick_gap();
        sink_hold    <= hold_len;
        evt_ch.ready <= (hold_len == 0);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (evt_ch.valid && evt_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_multi_slot_interval_timer_bank_top: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    timer_cmd_t  c;
    int          n_rand;
    int unsigned r;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.action    <= ACT_TICK;
    cmd_ch.slot      <= '0;
    cmd_ch.period_ms <= '0;
    cmd_ch.now_ms    <= '0;
    for (int i = 0; i < NSLOT; i++) begin
      tmr_period[i] = '0;
      tmr_base[i]   = '0;
      tmr_once[i]   = 1'b1;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int k = 0; k < NPLAN; k++) begin
      c = '{act: plan[k].act, slot: plan[k].slot, period: plan[k].period, now: plan[k].now};
      issue(c, plan[k].typed, plan[k].fires);
    end
    cur_now = 32'h8000_0064;

    // random traffic; bursts arm every slot and then fire them all in one tick
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        for (int s = 0; s < NSLOT; s++) begin
          c.act    = ($urandom_range(0, 1) == 0) ? ACT_START_PERIODIC : ACT_START_ONCE;
          c.slot   = 4'(s);
          c.period = $urandom_range(1, 4);
          c.now    = cur_now;
          issue(c, 1'b0, '0);
        end
        cur_now = cur_now + 4;
        c = '{act: ACT_TICK, slot: 4'($urandom()), period: $urandom(), now: cur_now};
        issue(c, 1'b0, '0);
        n_rand += NSLOT + 1;
      end else begin
        c.slot   = 4'($urandom());
        c.period = pick_period();
        if (r < 50) begin
          // tick: small steps, now and then a jump anywhere or near the wrap
          if ($urandom_range(0, 9) == 0)
            cur_now = ($urandom_range(0, 1) == 0) ? $urandom()
                                                  : 32'hFFFF_FFF0 + $urandom_range(0, 15);
          else
            cur_now = cur_now + $urandom_range(0, 8);
          c.act = ACT_TICK;
          c.now = cur_now;
        end else begin
          if (r < 72)      c.act = ACT_START_PERIODIC;
          else if (r < 88) c.act = ACT_START_ONCE;
          else             c.act = ACT_STOP;
          c.now = ($urandom_range(0, 6) == 0) ? $urandom() : cur_now;
        end
        issue(c, 1'b0, '0);
        n_rand++;
      end
    end
    cmd_ch.valid <= 1'b0;

    while (fire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run: %0d ticks, %0d starts, %0d stops", n_tick, n_start, n_stop);
    $display("run: %0d fire events checked, up to %0d from one tick", n_fire, max_fires);
    if (err_cnt == 0 && fire_q.size() == 0) begin
      $display("tb_multi_slot_interval_timer_bank_top: done, clean");
    end else begin
      $display("tb_multi_slot_interval_timer_bank_top: done, errors");
    end
    $finish;
  end

endmodule
